>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a sampled edge.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/ipv6nh_pkg.sv
`timescale 1ns / 1ps

package ipv6nh_pkg;

    // Command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Status codes
    localparam logic [2:0] STATUS_INSERTED = 3'd0;
    localparam logic [2:0] STATUS_UPDATED  = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_HIT      = 3'd3;
    localparam logic [2:0] STATUS_MISS     = 3'd4;

    // Request beat
    typedef struct packed {
        logic        command;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [47:0] mac_in;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mac_out;
    } rsp_t;

    // One table slot as stored in memory
    typedef struct packed {
        logic        valid;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [47:0] mac;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CHECK
    } hnt_state_t;

    // Byte-reverse a 32-bit word (network order to little-endian load)
    function automatic logic [31:0] bswap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // XOR of the four little-endian address words
    function automatic logic [31:0] addr_hash(input logic [63:0] hi, input logic [63:0] lo);
        return bswap32(hi[63:32]) ^ bswap32(hi[31:0]) ^ bswap32(lo[63:32]) ^ bswap32(lo[31:0]);
    endfunction

endpackage

>>> design/ipv6_neighbor_hash_table.sv
`timescale 1ns / 1ps
// IPv6 neighbor table: maps 128-bit addresses to 48-bit MACs, open addressing
// with linear probing over TABLE_DEPTH slots held in one synchronous RAM.
// Request channel: a beat on request is taken at a rising edge with start high
// and busy low. busy stays high until the result has been produced.
// Result channel: result_valid is high for exactly one cycle with result; the
// receiver cannot stall, the beat is taken at the edge that ends that cycle.
// After the accepting edge, busy stays high through the hash step, the
// home-slot read and one check per slot probed; the result strobe is in the
// first cycle with busy low, and a new request may be accepted in that same
// cycle. Depths that are not a power of two add hash steps for the home-slot
// remainder (reciprocal multiply, back-multiply and subtract, final
// correction). The RAM read of the next slot overlaps the compare of the
// current one. At worst all TABLE_DEPTH slots are probed.
// Reset: valid state lives in the RAM, so after rst_n releases the block
// runs a clearing pass over all TABLE_DEPTH slots, one slot per cycle, with
// busy high.
module ipv6_neighbor_hash_table
    import ipv6nh_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic result_valid,
    output rsp_t result
);

`include "assert_macros.svh"

    localparam int  ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int  REM_W    = ADDR_W + 1;
    localparam int  CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam bit  IS_POW2  = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);
    // floor(2^(31+ADDR_W) / depth): quotient estimate is low by at most one
    localparam logic [63:0] RECIP_WIDE = (64'd1 << (31 + ADDR_W)) / 64'(TABLE_DEPTH);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

    // Slot storage
    slot_t mem [TABLE_DEPTH];

    hnt_state_t        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [31:0]       hash_reg, hash_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [1:0]        step_reg, step_next;
    logic [31:0]       quot_reg, quot_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              result_valid_reg, result_valid_next;
    rsp_t              result_reg, result_next;
    slot_t             rd_data_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    slot_t             wr_data;

    logic [ADDR_W-1:0] cur_inc;
    logic [63:0]       recip_prod;
    logic [REM_W-1:0]  quot_back;
    logic              key_match;

    assign cur_inc    = (cur_reg == LAST_SLOT) ? '0 : ADDR_W'(cur_reg + 1'b1);
    assign recip_prod = {32'b0, hash_reg} * {32'b0, RECIP};
    assign quot_back  = REM_W'(quot_reg[REM_W-1:0] * REM_W'(TABLE_DEPTH));
    assign key_match  = (rd_data_reg.key_high == req_reg.ip_high) &&
                        (rd_data_reg.key_low == req_reg.ip_low);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hash_reg      <= hash_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        quot_reg      <= quot_next;
        cur_reg       <= cur_next;
        probe_cnt_reg <= probe_cnt_next;
        result_reg    <= result_next;
    end

    // Slot RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        hash_next         = hash_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        quot_next         = quot_reg;
        cur_next          = cur_reg;
        probe_cnt_next    = probe_cnt_reg;
        clr_cnt_next      = clr_cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        rd_en             = 1'b0;
        rd_addr           = cur_reg;
        wr_en             = 1'b0;
        wr_addr           = cur_reg;
        wr_data           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep every slot to invalid
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = (clr_cnt_reg == LAST_SLOT) ? '0
                                                          : ADDR_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    hash_next  = addr_hash(request.ip_high, request.ip_low);
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_HASH;
                end
            end

            ST_HASH:
            begin
                // home slot = hash mod depth
                if (IS_POW2)
                begin
                    cur_next       = ADDR_W'(hash_reg & 32'(TABLE_DEPTH - 1));
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE;
                end
                else if (step_reg == 2'd0)
                begin
                    // quotient estimate from the reciprocal
                    quot_next = 32'(recip_prod >> (31 + ADDR_W));
                    step_next = 2'd1;
                end
                else if (step_reg == 2'd1)
                begin
                    // remainder estimate, below twice the depth
                    rem_next  = REM_W'(hash_reg[REM_W-1:0] - quot_back);
                    step_next = 2'd2;
                end
                else
                begin
                    // one conditional subtract finishes the remainder
                    cur_next       = (rem_reg >= REM_W'(TABLE_DEPTH))
                                     ? ADDR_W'(rem_reg - REM_W'(TABLE_DEPTH))
                                     : rem_reg[ADDR_W-1:0];
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                // first read at the home slot
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                result_next.mac_out = '0;
                if (!rd_data_reg.valid)
                begin
                    // empty slot ends the walk
                    if (req_reg.command == CMD_UPDATE)
                    begin
                        wr_en                = 1'b1;
                        wr_data.valid        = 1'b1;
                        wr_data.key_high     = req_reg.ip_high;
                        wr_data.key_low      = req_reg.ip_low;
                        wr_data.mac          = req_reg.mac_in;
                        result_next.status   = STATUS_INSERTED;
                    end
                    else
                    begin
                        result_next.status   = STATUS_MISS;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else if (key_match)
                begin
                    if (req_reg.command == CMD_UPDATE)
                    begin
                        wr_en              = 1'b1;
                        wr_data.valid      = 1'b1;
                        wr_data.key_high   = req_reg.ip_high;
                        wr_data.key_low    = req_reg.ip_low;
                        wr_data.mac        = req_reg.mac_in;
                        result_next.status = STATUS_UPDATED;
                    end
                    else
                    begin
                        result_next.status  = STATUS_HIT;
                        result_next.mac_out = rd_data_reg.mac;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else if (probe_cnt_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    // every slot probed
                    result_next.status = (req_reg.command == CMD_UPDATE) ? STATUS_FULL
                                                                         : STATUS_MISS;
                    result_valid_next  = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    // read the next slot while moving on
                    rd_en          = 1'b1;
                    rd_addr        = cur_inc;
                    cur_next       = cur_inc;
                    probe_cnt_next = CNT_W'(probe_cnt_reg + 1'b1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `ASSERT_CLK(a_strobe_single, result_valid_reg |=> !result_valid_reg, "result strobe longer than one cycle")
    `ASSERT_CLK(a_mac_only_on_hit, (result_valid_reg && result_reg.status != STATUS_HIT) |-> (result_reg.mac_out == '0), "mac_out nonzero without a hit")
    `ASSERT_NEVER(a_no_write_idle, (state_reg == ST_IDLE) && wr_en, "slot write while idle")
    `ASSERT_CLK(a_accept_starts_hash, (start && !busy) |=> (state_reg == ST_HASH), "accepted request did not start hashing")

endmodule
